/* hw/rtl/tsds_pkg.sv */
// shared types, character codes and slot weights for the time string parser
package tsds_pkg;

  localparam int SlotCount = 10;
  localparam int ZoneSlot  = 6;
  localparam int IdxW      = $clog2(SlotCount + 1);
  localparam int DigitW    = 4;
  localparam int CharW     = 8;
  localparam int SecW      = 20;
  localparam int SumW      = SecW + 1;
  localparam int WeightW   = 16;

  localparam logic [SumW-1:0] HalfDaySec = SumW'(43200);

  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChLowH   = 8'h68;
  localparam logic [CharW-1:0] ChUpH    = 8'h48;
  localparam logic [CharW-1:0] ChColon  = 8'h3a;
  localparam logic [CharW-1:0] ChPlus   = 8'h2b;
  localparam logic [CharW-1:0] ChMinus  = 8'h2d;
  localparam logic [CharW-1:0] ChUpP    = 8'h50;
  localparam logic [CharW-1:0] ChLowP   = 8'h70;
  localparam logic [CharW-1:0] ChUpM    = 8'h4d;
  localparam logic [CharW-1:0] ChLowM   = 8'h6d;
  localparam logic [CharW-1:0] ChDot    = 8'h2e;

  // seconds carried by one unit of each slot: HH MM SS TZHH TZMM
  localparam logic [WeightW-1:0] SlotWeight [SlotCount] = '{
    16'd36000, 16'd3600, 16'd600, 16'd60, 16'd10, 16'd1,
    16'd36000, 16'd3600, 16'd600, 16'd60
  };

  typedef logic [SlotCount-1:0][DigitW-1:0] slots_t;

  // everything the sum stage needs from one finished string
  typedef struct packed {
    slots_t digits;
    logic   afternoon;
    logic   zone_adds;
  } snap_t;

endpackage

/* hw/rtl/time_string_to_day_seconds.sv */
// top level: time string characters in, signed seconds of day out
// the accepted last character fills the snapshot register, and the result word is then registered from it
// throughput: one character per cycle while in_stall is low; the parser state updates at each accepted character
// a finished string waits in a snapshot register while the output register is held,
// so input stalls only when both of them are full and the output is stalled
// reset: synchronous, clears all slots, pointers and valid flags
module time_string_to_day_seconds (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tsds_pkg::CharW-1:0]        char_code,
  input  logic                              last_char,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tsds_pkg::SecW-1:0]  day_seconds
);
  import tsds_pkg::*;

  logic  accept;
  logic  snap_valid;
  logic  snap_take;
  snap_t snap;

  // the snapshot slot must be free, or leaving this cycle, before a word enters
  assign in_stall = snap_valid && !snap_take;
  assign accept   = in_valid && !in_stall;

  // per-character parsing; snapshot of the padded slots on the last character
  tsds_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_code  (char_code),
    .last_char  (last_char),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // constant-weight sum of the ten slots, half day and zone into the output register
  tsds_sum u_sum (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap        (snap),
    .snap_take   (snap_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .day_seconds (day_seconds)
  );

endmodule

/* hw/rtl/tsds_parse.sv */
// character parser: slot filling, padding, zone sign, afternoon detect, snapshot register
module tsds_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [tsds_pkg::CharW-1:0] char_code,
  input  logic                       last_char,
  input  logic                       snap_take,
  output logic                       snap_valid,
  output tsds_pkg::snap_t            snap
);
  import tsds_pkg::*;

  slots_t            slots;
  slots_t            slots_next;
  slots_t            fin_slots;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   idx_next;
  logic              zone_adds;
  logic              zone_adds_next;
  logic              afternoon;
  logic              pm_hit;
  logic [CharW-1:0]  prev_char;
  logic [CharW-1:0]  prev_prev_char;
  logic              in_range;
  logic              is_digit;
  logic              is_mark;
  logic              is_sign;
  logic              do_pad;
  logic              fin_pad;
  logic              snap_valid_next;

  assign pm_hit = (prev_char == ChUpP  && char_code == ChUpM) ||
                  (prev_char == ChLowP && char_code == ChLowM) ||
                  (prev_prev_char == ChUpP  && prev_char == ChDot && char_code == ChUpM) ||
                  (prev_prev_char == ChLowP && prev_char == ChDot && char_code == ChLowM);

  assign in_range = idx < IdxW'(SlotCount);
  assign is_digit = char_code >= ChZero && char_code <= ChNine;
  assign is_mark  = char_code == ChLowH || char_code == ChUpH || char_code == ChColon;
  assign is_sign  = char_code == ChPlus || char_code == ChMinus;
  assign do_pad   = in_range && idx[0] && (is_mark || is_sign);

  always_comb begin
    slots_next     = slots;
    idx_next       = idx;
    zone_adds_next = zone_adds;
    // lone digit moves to the units place of its pair
    if (do_pad) begin
      for (int k = 1; k < SlotCount; k++) begin
        if (idx == IdxW'(k)) slots_next[k] = slots[k-1];
      end
      for (int k = 0; k < SlotCount - 1; k++) begin
        if (idx == IdxW'(k + 1)) slots_next[k] = '0;
      end
    end
    if (in_range) begin
      if (is_digit) begin
        for (int k = 0; k < SlotCount; k++) begin
          if (idx == IdxW'(k)) slots_next[k] = char_code[DigitW-1:0];
        end
        idx_next = idx + IdxW'(1);
      end else if (is_mark) begin
        if (idx[0]) idx_next = idx + IdxW'(1);
      end else if (is_sign) begin
        if (char_code == ChMinus) zone_adds_next = 1'b1;
        idx_next = IdxW'(ZoneSlot);
      end
    end
  end

  // trailing single digit gets padded before the sum
  assign fin_pad = idx_next[0] && (idx_next < IdxW'(SlotCount));

  always_comb begin
    fin_slots = slots_next;
    if (fin_pad) begin
      for (int k = 1; k < SlotCount; k++) begin
        if (idx_next == IdxW'(k)) fin_slots[k] = slots_next[k-1];
      end
      for (int k = 0; k < SlotCount - 1; k++) begin
        if (idx_next == IdxW'(k + 1)) fin_slots[k] = '0;
      end
    end
  end

  assign snap_valid_next = (snap_valid && !snap_take) || (accept && last_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      slots          <= '0;
      idx            <= '0;
      zone_adds      <= 1'b0;
      afternoon      <= 1'b0;
      prev_char      <= '0;
      prev_prev_char <= '0;
      snap_valid     <= 1'b0;
    end else begin
      snap_valid <= snap_valid_next;
      if (accept) begin
        if (last_char) begin
          slots          <= '0;
          idx            <= '0;
          zone_adds      <= 1'b0;
          afternoon      <= 1'b0;
          prev_char      <= '0;
          prev_prev_char <= '0;
        end else begin
          slots          <= slots_next;
          idx            <= idx_next;
          zone_adds      <= zone_adds_next;
          afternoon      <= afternoon || pm_hit;
          prev_char      <= char_code;
          prev_prev_char <= prev_char;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_char) begin
      snap.digits    <= fin_slots;
      snap.afternoon <= afternoon || pm_hit;
      snap.zone_adds <= zone_adds_next;
    end
  end

endmodule

/* hw/rtl/tsds_sum.sv */
// weighted slot sum with zone correction and output register
module tsds_sum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              snap_valid,
  input  tsds_pkg::snap_t                   snap,
  output logic                              snap_take,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tsds_pkg::SecW-1:0]  day_seconds
);
  import tsds_pkg::*;

  logic            load;
  logic [SumW-1:0] local_sec;
  logic [SumW-1:0] zone_sec;
  logic [SumW-1:0] base_sec;
  logic [SumW-1:0] total;

  assign load      = !out_valid || !out_stall;
  assign snap_take = snap_valid && load;

  always_comb begin
    local_sec = '0;
    zone_sec  = '0;
    for (int k = 0; k < ZoneSlot; k++) begin
      local_sec = local_sec + SumW'(snap.digits[k]) * SumW'(SlotWeight[k]);
    end
    for (int k = ZoneSlot; k < SlotCount; k++) begin
      zone_sec = zone_sec + SumW'(snap.digits[k]) * SumW'(SlotWeight[k]);
    end
    base_sec = local_sec + (snap.afternoon ? HalfDaySec : '0);
    total    = snap.zone_adds ? base_sec + zone_sec : base_sec - zone_sec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      day_seconds <= total[SecW-1:0];
    end
  end

endmodule

/* hw/rtl/tsds_check.sv */
// port-level checker for the time string parser, bound to the top level
module tsds_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [tsds_pkg::CharW-1:0]        char_code,
  input logic                              last_char,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [tsds_pkg::SecW-1:0]  day_seconds
);
  import tsds_pkg::*;

  // a stalled input word holds still
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(char_code) && $stable(last_char))
    else $error("input word changed while stalled");

  // held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(day_seconds))
    else $error("result word changed while stalled");

  // input only backs up when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind time_string_to_day_seconds tsds_check u_tsds_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .char_code   (char_code),
  .last_char   (last_char),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .day_seconds (day_seconds)
);
